### rtl/websocket_frame_decoder_macros.svh
// Assertion macros used by the checker of the frame decoder
`ifndef WEBSOCKET_FRAME_DECODER_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define WFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wfd_pkg.sv
// Shared types and constants of the WebSocket frame decoder
`default_nettype none

package wfd_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [2:0] KeyBytes = 3'd4;

  localparam logic KindHeader = 1'b0;
  localparam logic KindPayload = 1'b1;
  localparam logic StatusOk = 1'b0;
  localparam logic StatusTrunc = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] frame_len;
    logic [31:0] mask_key;
    logic [7:0]  data;
    logic [1:0]  lane;
    logic        last;
    logic [63:0] byte_total;
  } rec_t;

endpackage

`default_nettype wire

### rtl/wfd_front.sv
// Front parser: header decode, frame state and result records
`default_nettype none

module wfd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          buffer_end_i,
  output wfd_pkg::rec_t      rec_o,
  output logic               rec_valid_o
);

  localparam logic [2:0] PhFirst   = 3'd0;
  localparam logic [2:0] PhSecond  = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhKey     = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [63:0] length_q, length_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  key_left_q, key_left_d;
  logic [63:0] pidx_q, pidx_d;
  logic [63:0] count_q, count_d;
  logic [8:0]  flags_q, flags_d;

  always_comb begin
    logic [63:0] consumed;
    logic        header_done;
    logic        emit;
    logic        complete;
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  lane;
    logic        status;
    logic        last;

    consumed    = (count_q == '1) ? count_q : count_q + 64'd1;
    header_done = 1'b0;
    emit        = 1'b0;
    complete    = 1'b0;
    kind        = wfd_pkg::KindHeader;
    data        = 8'd0;
    lane        = 2'd0;
    status      = wfd_pkg::StatusOk;
    last        = 1'b0;

    phase_d    = phase_q;
    len_left_d = len_left_q;
    length_d   = length_q;
    key_d      = key_q;
    key_left_d = key_left_q;
    pidx_d     = pidx_q;
    count_d    = consumed;
    flags_d    = flags_q;

    unique case (phase_q)
      PhSecond: begin
        flags_d[0] = flags_q[0] | data_byte_i[7];
        if (data_byte_i[6:0] == wfd_pkg::LenCode16) begin
          len_left_d = wfd_pkg::ExtBytes16;
          phase_d    = PhExtLen;
        end else if (data_byte_i[6:0] == wfd_pkg::LenCode64) begin
          len_left_d = wfd_pkg::ExtBytes64;
          phase_d    = PhExtLen;
        end else begin
          length_d    = {57'd0, data_byte_i[6:0]};
          header_done = 1'b1;
        end
      end
      PhExtLen: begin
        length_d   = {length_q[55:0], data_byte_i};
        len_left_d = len_left_q - 4'd1;
        if (len_left_d == 4'd0) begin
          header_done = 1'b1;
        end
      end
      PhKey: begin
        key_d      = {key_q[23:0], data_byte_i};
        key_left_d = key_left_q - 3'd1;
        if (key_left_d == 3'd0) begin
          phase_d  = PhPayload;
          complete = (length_q == 64'd0);
          emit     = 1'b1;
        end
      end
      PhPayload: begin
        kind     = wfd_pkg::KindPayload;
        data     = data_byte_i;
        lane     = pidx_q[1:0];
        pidx_d   = pidx_q + 64'd1;
        complete = (pidx_d == length_q);
        emit     = 1'b1;
      end
      default: begin
        flags_d  = {data_byte_i[7], data_byte_i[6:4], data_byte_i[3:0], 1'b0};
        length_d = 64'd0;
        key_d    = 32'd0;
        pidx_d   = 64'd0;
        phase_d  = PhSecond;
      end
    endcase

    if (header_done) begin
      if (flags_d[0]) begin
        key_left_d = wfd_pkg::KeyBytes;
        phase_d    = PhKey;
      end else begin
        phase_d  = PhPayload;
        complete = (length_d == 64'd0);
        emit     = 1'b1;
      end
    end

    last = complete;
    if (!complete && buffer_end_i) begin
      status = wfd_pkg::StatusTrunc;
      last   = 1'b1;
      emit   = 1'b1;
    end

    rec_o.kind       = kind;
    rec_o.status     = status;
    rec_o.fin        = flags_d[8];
    rec_o.rsv        = flags_d[7:5];
    rec_o.opcode     = flags_d[4:1];
    rec_o.masked     = flags_d[0];
    rec_o.frame_len  = length_d;
    rec_o.mask_key   = key_d;
    rec_o.data       = data;
    rec_o.lane       = lane;
    rec_o.last       = last;
    rec_o.byte_total = last ? consumed : 64'd0;
    rec_valid_o      = valid_i & emit;

    if (last) begin
      phase_d    = PhFirst;
      len_left_d = 4'd0;
      length_d   = 64'd0;
      key_d      = 32'd0;
      key_left_d = 3'd0;
      pidx_d     = 64'd0;
      count_d    = 64'd0;
      flags_d    = 9'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhFirst;
      len_left_q <= 4'd0;
      length_q   <= 64'd0;
      key_q      <= 32'd0;
      key_left_q <= 3'd0;
      pidx_q     <= 64'd0;
      count_q    <= 64'd0;
      flags_q    <= 9'd0;
    end else if (valid_i) begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      length_q   <= length_d;
      key_q      <= key_d;
      key_left_q <= key_left_d;
      pidx_q     <= pidx_d;
      count_q    <= count_d;
      flags_q    <= flags_d;
    end
  end

endmodule

`default_nettype wire

### rtl/wfd_fifo.sv
// Record queue between the parser and the output stage
`default_nettype none

module wfd_fifo #(
  parameter int unsigned Depth = wfd_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wfd_pkg::rec_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output wfd_pkg::rec_t      data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wfd_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/wfd_back.sv
// Output stage: unmask payload bytes and hold the result register
`default_nettype none

module wfd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wfd_pkg::rec_t      rec_i,
  input  wire logic          rec_empty_i,
  output logic               rec_pop_o,
  output wfd_pkg::rec_t      out_o,
  output logic               out_valid_o,
  input  wire logic          take_i
);

  logic          valid_q;
  wfd_pkg::rec_t out_q, out_d;
  logic [7:0]    key_byte;

  always_comb begin
    unique case (rec_i.lane)
      2'd0:    key_byte = rec_i.mask_key[31:24];
      2'd1:    key_byte = rec_i.mask_key[23:16];
      2'd2:    key_byte = rec_i.mask_key[15:8];
      default: key_byte = rec_i.mask_key[7:0];
    endcase
    out_d      = rec_i;
    out_d.data = rec_i.data ^ ((rec_i.masked && rec_i.kind == wfd_pkg::KindPayload)
                               ? key_byte : 8'd0);
    out_d.lane = 2'd0;
  end

  assign rec_pop_o   = ~rec_empty_i & (~valid_q | take_i);
  assign out_o       = out_q;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rec_pop_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/websocket_frame_decoder.sv
// With the output register free, a result passes through the record queue and is then held in the output register.
// Throughput: one byte per cycle while full is low, set by the parser state update on each accepted byte.
// Header bytes that complete neither the header nor the buffer produce no result.
// The record queue absorbs output stalls; full rises when it holds QueueDepth records.
// Reset clears the parser state, the queue pointers and count, and the output valid flag.
`default_nettype none

module websocket_frame_decoder #(
  parameter int unsigned QueueDepth = wfd_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        buffer_end_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind_o,
  output logic             status_o,
  output logic             fin_o,
  output logic [2:0]       rsv_o,
  output logic [3:0]       opcode_o,
  output logic             masked_o,
  output logic [63:0]      frame_len_o,
  output logic [31:0]      mask_key_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_o,
  output logic [63:0]      byte_total_o
);

  logic          accept;
  logic          rec_valid;
  wfd_pkg::rec_t front_rec;
  wfd_pkg::rec_t queue_rec;
  wfd_pkg::rec_t out_rec;
  logic          queue_empty;
  logic          queue_pop;
  logic          out_valid;

  assign accept = push & ~full;

  wfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .rec_o        (front_rec),
    .rec_valid_o  (rec_valid)
  );

  wfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .data_i  (front_rec),
    .full_o  (full),
    .pop_i   (queue_pop),
    .data_o  (queue_rec),
    .empty_o (queue_empty)
  );

  wfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (queue_rec),
    .rec_empty_i (queue_empty),
    .rec_pop_o   (queue_pop),
    .out_o       (out_rec),
    .out_valid_o (out_valid),
    .take_i      (pop)
  );

  assign empty          = ~out_valid;
  assign kind_o         = out_rec.kind;
  assign status_o       = out_rec.status;
  assign fin_o          = out_rec.fin;
  assign rsv_o          = out_rec.rsv;
  assign opcode_o       = out_rec.opcode;
  assign masked_o       = out_rec.masked;
  assign frame_len_o    = out_rec.frame_len;
  assign mask_key_o     = out_rec.mask_key;
  assign payload_byte_o = out_rec.data;
  assign last_o         = out_rec.last;
  assign byte_total_o   = out_rec.byte_total;

endmodule

`default_nettype wire

### rtl/wfd_checker.sv
// Port-level checker of the frame decoder and its bind
`default_nettype none

`include "websocket_frame_decoder_macros.svh"

module wfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        kind_o,
  input wire logic        status_o,
  input wire logic        masked_o,
  input wire logic [31:0] mask_key_o,
  input wire logic [7:0]  payload_byte_o,
  input wire logic        last_o,
  input wire logic [63:0] byte_total_o
);

  `WFD_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(payload_byte_o) && $stable(byte_total_o), "result changed")
  `WFD_ASSERT_IMPL(a_trunc_last, !empty && status_o, last_o, "truncated result not marked last")
  `WFD_ASSERT_IMPL(a_header_byte, !empty && !kind_o, payload_byte_o == 8'd0, "header result with data")
  `WFD_ASSERT_IMPL(a_count_last, !empty && !last_o, (byte_total_o == 64'd0) && (masked_o || (mask_key_o == 32'd0)), "bad count or key")

endmodule

bind websocket_frame_decoder wfd_checker u_wfd_checker (.*);

`default_nettype wire

### sim/tb_websocket_frame_decoder.sv
// Self-checking testbench for the WebSocket frame decoder: directed and random byte streams
`timescale 1ns / 100ps

module tb_websocket_frame_decoder;

  localparam int NumDirected = 24;
  localparam int NumRandom = 900;
  localparam int NumFields = 11;
  localparam int DrainCycles = 12;
  localparam int CycleLimit = 200000;

  typedef enum logic [2:0] {
    PhFirst,
    PhSecond,
    PhExtLen,
    PhKey,
    PhPayload
  } dec_phase_e;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] frame_len;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
    logic        last;
    logic [63:0] byte_total;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       buf_end;
  } stim_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       buf_end;
    logic       typed;
    frame_rec_t want;
  } stim_row_t;

  localparam frame_rec_t NoRec = '0;

  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{8'h81, 1'b1, 1'b1, '{wfd_pkg::KindHeader, wfd_pkg::StatusTrunc, 1'b1, 3'd0,
                           4'h1, 1'b0, 64'd0, 32'd0, 8'd0, 1'b1, 64'd1}},
    '{8'h8A, 1'b0, 1'b0, NoRec},
    '{8'h00, 1'b0, 1'b1, '{wfd_pkg::KindHeader, wfd_pkg::StatusOk, 1'b1, 3'd0,
                           4'hA, 1'b0, 64'd0, 32'd0, 8'd0, 1'b1, 64'd2}},
    '{8'hF2, 1'b0, 1'b0, NoRec},
    '{8'h82, 1'b0, 1'b0, NoRec},
    '{8'h12, 1'b0, 1'b0, NoRec},
    '{8'h34, 1'b0, 1'b0, NoRec},
    '{8'h56, 1'b0, 1'b0, NoRec},
    '{8'h78, 1'b0, 1'b0, NoRec},
    '{8'h5A, 1'b0, 1'b0, NoRec},
    '{8'hA5, 1'b0, 1'b0, NoRec},
    '{8'h0F, 1'b0, 1'b0, NoRec},
    '{8'h7E, 1'b0, 1'b0, NoRec},
    '{8'h00, 1'b0, 1'b0, NoRec},
    '{8'h01, 1'b0, 1'b0, NoRec},
    '{8'hFF, 1'b1, 1'b0, NoRec},
    '{8'hFF, 1'b0, 1'b0, NoRec},
    '{8'hFF, 1'b0, 1'b0, NoRec},
    '{8'hFF, 1'b0, 1'b0, NoRec},
    '{8'hFF, 1'b1, 1'b1, '{wfd_pkg::KindHeader, wfd_pkg::StatusTrunc, 1'b1, 3'd7,
                           4'hF, 1'b1, 64'hFFFF, 32'd0, 8'd0, 1'b1, 64'd4}},
    '{8'h82, 1'b0, 1'b0, NoRec},
    '{8'h05, 1'b0, 1'b0, NoRec},
    '{8'hAA, 1'b0, 1'b0, NoRec},
    '{8'h55, 1'b1, 1'b0, NoRec}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        buffer_end_i;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic        status_o;
  logic        fin_o;
  logic [2:0]  rsv_o;
  logic [3:0]  opcode_o;
  logic        masked_o;
  logic [63:0] frame_len_o;
  logic [31:0] mask_key_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;
  logic [63:0] byte_total_o;

  websocket_frame_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .buffer_end_i   (buffer_end_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .fin_o          (fin_o),
    .rsv_o          (rsv_o),
    .opcode_o       (opcode_o),
    .masked_o       (masked_o),
    .frame_len_o    (frame_len_o),
    .mask_key_o     (mask_key_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o),
    .byte_total_o   (byte_total_o)
  );

  dec_phase_e  dec_phase;
  logic [3:0]  len_left;
  logic [63:0] len_acc;
  logic [31:0] key_acc;
  logic [2:0]  key_left;
  logic [63:0] pay_idx;
  logic [63:0] byte_cnt;
  logic        hdr_fin;
  logic [2:0]  hdr_rsv;
  logic [3:0]  hdr_op;
  logic        hdr_mask;

  frame_rec_t  expected_q [$];
  stim_byte_t  frame_q [$];
  int          err_cnt = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          payloads_seen = 0;
  int          frames_seen = 0;
  int          trunc_seen = 0;
  int          burst_left = 0;
  int          cycle_cnt = 0;
  int          pat_cnt = 0;
  logic [15:0] stall_pat = 16'hFFFF;

  always #10 clk_i = ~clk_i;

  function automatic void clear_frame();
    dec_phase = PhFirst;
    len_left = '0;
    len_acc = '0;
    key_acc = '0;
    key_left = '0;
    pay_idx = '0;
    byte_cnt = '0;
    hdr_fin = 1'b0;
    hdr_rsv = '0;
    hdr_op = '0;
    hdr_mask = 1'b0;
  endfunction

  function automatic frame_rec_t make_rec(input logic kind, input logic status,
                                          input logic [7:0] pbyte, input logic is_last);
    frame_rec_t r;
    r.kind = kind;
    r.status = status;
    r.fin = hdr_fin;
    r.rsv = hdr_rsv;
    r.opcode = hdr_op;
    r.masked = hdr_mask;
    r.frame_len = len_acc;
    r.mask_key = key_acc;
    r.payload_byte = pbyte;
    r.last = is_last;
    r.byte_total = is_last ? byte_cnt : 64'd0;
    return r;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic e, output frame_rec_t r);
    frame_rec_t res;
    bit         hdr_done;
    bit         produced;
    bit         done;
    logic [7:0] key_byte;
    hdr_done = 1'b0;
    produced = 1'b0;
    done = 1'b0;
    res = '0;
    if (byte_cnt != '1) byte_cnt++;
    case (dec_phase)
      PhSecond: begin
        hdr_mask = b[7];
        if (b[6:0] == wfd_pkg::LenCode16) begin
          len_left = wfd_pkg::ExtBytes16;
          dec_phase = PhExtLen;
        end else if (b[6:0] == wfd_pkg::LenCode64) begin
          len_left = wfd_pkg::ExtBytes64;
          dec_phase = PhExtLen;
        end else begin
          len_acc = {57'd0, b[6:0]};
          hdr_done = 1'b1;
        end
      end
      PhExtLen: begin
        len_acc = {len_acc[55:0], b};
        len_left = len_left - 4'd1;
        if (len_left == 4'd0) hdr_done = 1'b1;
      end
      PhKey: begin
        key_acc = {key_acc[23:0], b};
        key_left = key_left - 3'd1;
        if (key_left == 3'd0) begin
          dec_phase = PhPayload;
          done = (len_acc == 64'd0);
          res = make_rec(wfd_pkg::KindHeader, wfd_pkg::StatusOk, 8'd0, done);
          produced = 1'b1;
        end
      end
      PhPayload: begin
        key_byte = hdr_mask ? 8'(key_acc >> (8 * (3 - int'(pay_idx[1:0])))) : 8'h00;
        pay_idx++;
        done = (pay_idx == len_acc);
        res = make_rec(wfd_pkg::KindPayload, wfd_pkg::StatusOk, b ^ key_byte, done);
        produced = 1'b1;
      end
      default: begin
        hdr_fin = b[7];
        hdr_rsv = b[6:4];
        hdr_op = b[3:0];
        hdr_mask = 1'b0;
        len_acc = '0;
        key_acc = '0;
        pay_idx = '0;
        dec_phase = PhSecond;
      end
    endcase

    if (hdr_done) begin
      if (hdr_mask) begin
        key_left = wfd_pkg::KeyBytes;
        dec_phase = PhKey;
      end else begin
        dec_phase = PhPayload;
        done = (len_acc == 64'd0);
        res = make_rec(wfd_pkg::KindHeader, wfd_pkg::StatusOk, 8'd0, done);
        produced = 1'b1;
      end
    end

    if (done) begin
      clear_frame();
      r = res;
      return 1'b1;
    end
    if (e) begin
      if (produced) begin
        res.status = wfd_pkg::StatusTrunc;
        res.last = 1'b1;
        res.byte_total = byte_cnt;
      end else begin
        res = make_rec(wfd_pkg::KindHeader, wfd_pkg::StatusTrunc, 8'd0, 1'b1);
      end
      clear_frame();
      r = res;
      return 1'b1;
    end
    r = res;
    return produced;
  endfunction

  function automatic logic [63:0] field_of(input frame_rec_t r, input int idx,
                                           output string nm);
    case (idx)
      0:  begin nm = "kind";         return 64'(r.kind);         end
      1:  begin nm = "status";       return 64'(r.status);       end
      2:  begin nm = "fin";          return 64'(r.fin);          end
      3:  begin nm = "rsv";          return 64'(r.rsv);          end
      4:  begin nm = "opcode";       return 64'(r.opcode);       end
      5:  begin nm = "masked";       return 64'(r.masked);       end
      6:  begin nm = "frame_len";    return r.frame_len;         end
      7:  begin nm = "mask_key";     return 64'(r.mask_key);     end
      8:  begin nm = "payload_byte"; return 64'(r.payload_byte); end
      9:  begin nm = "last";         return 64'(r.last);         end
      default: begin nm = "byte_total"; return r.byte_total; end
    endcase
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input frame_rec_t got);
    frame_rec_t  want;
    string       nm;
    logic [63:0] gv;
    logic [63:0] wv;
    results_seen++;
    if (got.kind == wfd_pkg::KindPayload) payloads_seen++;
    if (got.last === 1'b1) frames_seen++;
    if (got.status == wfd_pkg::StatusTrunc) trunc_seen++;
    if (expected_q.size() == 0) begin
      report_error($sformatf("result %0d transferred with nothing expected", results_seen));
      return;
    end
    want = expected_q.pop_front();
    for (int i = 0; i < NumFields; i++) begin
      gv = field_of(got, i, nm);
      wv = field_of(want, i, nm);
      if (gv !== wv)
        report_error($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                               results_seen, nm, gv, wv));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        check_result('{kind_o, status_o, fin_o, rsv_o, opcode_o, masked_o, frame_len_o,
                       mask_key_o, payload_byte_o, last_o, byte_total_o});
      pat_cnt++;
      if (pat_cnt % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hFFFF;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
      end else begin
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      pop <= stall_pat[0];
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("websocket_frame_decoder verification failed");
      $finish;
    end
  end

  task automatic pace();
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_expected();
    push <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                           input frame_rec_t want);
    frame_rec_t pred;
    bit         has;
    pace();
    push <= 1'b1;
    data_byte_i <= b;
    buffer_end_i <= e;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    has = decode_byte(b, e, pred);
    if (typed) expected_q.push_back(want);
    else if (has) expected_q.push_back(pred);
    items_sent++;
  endtask

  task automatic build_frame();
    logic [7:0]  hdr0;
    logic        msk;
    logic [63:0] len;
    logic [31:0] key;
    int          form;
    int          pay_n;
    int          total;
    int          cut;
    bit          huge;
    frame_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      pay_n = $urandom_range(1, 6);
      for (int i = 0; i < pay_n; i++)
        frame_q.push_back('{8'($urandom), (i == pay_n - 1) || ($urandom_range(0, 3) == 0)});
      return;
    end
    hdr0 = 8'($urandom);
    msk = 1'($urandom);
    form = $urandom_range(0, 9);
    frame_q.push_back('{hdr0, 1'b0});
    if (form < 6) begin
      case ($urandom_range(0, 5))
        0: len = 64'd125;
        1: len = 64'($urandom_range(0, 125));
        default: len = 64'($urandom_range(0, 12));
      endcase
      frame_q.push_back('{{msk, len[6:0]}, 1'b0});
    end else if (form < 8) begin
      len = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 65535))
                                        : 64'($urandom_range(0, 16));
      frame_q.push_back('{{msk, wfd_pkg::LenCode16}, 1'b0});
      frame_q.push_back('{len[15:8], 1'b0});
      frame_q.push_back('{len[7:0], 1'b0});
    end else begin
      len = ($urandom_range(0, 3) == 0) ? {32'($urandom), 32'($urandom)}
                                        : 64'($urandom_range(0, 16));
      frame_q.push_back('{{msk, wfd_pkg::LenCode64}, 1'b0});
      for (int i = 7; i >= 0; i--) frame_q.push_back('{len[8*i +: 8], 1'b0});
    end
    if (msk) begin
      key = $urandom;
      for (int i = 3; i >= 0; i--) frame_q.push_back('{key[8*i +: 8], 1'b0});
    end
    huge = (len > 64'd40);
    pay_n = huge ? $urandom_range(0, 6) : int'(len);
    for (int i = 0; i < pay_n; i++) frame_q.push_back('{8'($urandom), 1'b0});
    total = frame_q.size();
    if (huge || $urandom_range(0, 9) == 0) begin
      cut = huge ? $urandom_range(0, total - 1) : $urandom_range(0, total - 2);
      frame_q = frame_q[0:cut];
      frame_q[cut].buf_end = 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      frame_q[total - 1].buf_end = 1'b1;
    end
  endtask

  initial begin
    int frame_no;
    frame_no = 0;
    push <= 1'b0;
    data_byte_i <= 8'h00;
    buffer_end_i <= 1'b0;
    rst_ni <= 1'b0;
    clear_frame();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i])
      send_byte(DirectedRows[i].data, DirectedRows[i].buf_end, DirectedRows[i].typed,
                DirectedRows[i].want);
    drain_expected();

    while (items_sent < NumDirected + NumRandom) begin
      build_frame();
      foreach (frame_q[i]) send_byte(frame_q[i].data, frame_q[i].buf_end, 1'b0, NoRec);
      frame_no++;
      if (frame_no % 20 == 0) drain_expected();
    end

    drain_expected();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d bytes in %0d random frames plus a directed prefix.",
             items_sent, frame_no);
    $display("Checked %0d results: %0d payload bytes, %0d frame ends, %0d truncations.",
             results_seen, payloads_seen, frames_seen, trunc_seen);
    if (err_cnt == 0) begin
      $display("websocket_frame_decoder verification clean");
    end else begin
      $display("websocket_frame_decoder verification failed");
    end
    $finish;
  end

endmodule
